[rtl/segment_intersection_test_defines.svh]
// Assertion macros shared by the segment intersection RTL.
// Include by bare file name; no other dependencies.
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SIT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sit_pkg.sv]
// Shared types and constants for the segment intersection test.
// No dependencies.
package sit_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // Orientation of a point against a directed line
    typedef enum logic [1:0] {
        ORIENT_COLLINEAR = 2'd0,
        ORIENT_POS       = 2'd1,
        ORIENT_NEG       = 2'd2
    } orient_t;

    // Load enables for the two register stages inside the orientation unit
    typedef struct packed {
        logic mul;
        logic cmp;
    } sit_stage_en_t;

endpackage

[rtl/segment_intersection_test.sv]
// Top level of the segment intersection test: four-stage pipeline.
// Depends on sit_pkg, sit_orient and segment_intersection_test_defines.svh.
//
//  channel | ports                        | direction | handshake
//  input   | s_ax .. s_dy (signed coords) | in        | s_valid / s_ready
//  result  | m_intersects                 | out       | m_valid / m_ready
//
// One word per cycle enters while s_ready is high; m_valid rises once that word has reached the merge stage.
// Stages: coordinate differences and box checks, multiplies, compares, merge.
// Each stage holds its word while the stage after it is full and stalled;
// empty stages keep filling, so a waiting result stalls the input only once
// all four stages are full.
// Reset (aresetn low, synchronous) clears the stage valid bits only.
`include "segment_intersection_test_defines.svh"

module segment_intersection_test
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_ax,
    input  logic signed [COORD_WIDTH-1:0] s_ay,
    input  logic signed [COORD_WIDTH-1:0] s_bx,
    input  logic signed [COORD_WIDTH-1:0] s_by,
    input  logic signed [COORD_WIDTH-1:0] s_cx,
    input  logic signed [COORD_WIDTH-1:0] s_cy,
    input  logic signed [COORD_WIDTH-1:0] s_dx,
    input  logic signed [COORD_WIDTH-1:0] s_dy,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_intersects
);

    localparam int W = COORD_WIDTH;

    // Orientation slots: ABC, ABD, CDA, CDB
    localparam int NOR = 4;
    localparam int O_ABC = 0;
    localparam int O_ABD = 1;
    localparam int O_CDA = 2;
    localparam int O_CDB = 3;

    // Stage valid bits and load enables
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic en1, en2, en3, en4;

    // Stage 1 payload
    logic signed [W:0] ux_reg [NOR];
    logic signed [W:0] uy_reg [NOR];
    logic signed [W:0] vx_reg [NOR];
    logic signed [W:0] vy_reg [NOR];
    logic [NOR-1:0]    box1_reg;
    logic [NOR-1:0]    box1_next;

    // Stages 2 and 3 carry the box bits alongside the orientation unit
    logic [NOR-1:0]    box2_reg;
    logic [NOR-1:0]    box3_reg;
    orient_t           orient [NOR];
    sit_stage_en_t     oen;

    // Stage 4: output register
    logic              hit_reg;
    logic              hit_next;

    // Point p inside the closed box spanned by e0 and e1
    function automatic logic in_box(
        input logic signed [W-1:0] e0x, input logic signed [W-1:0] e0y,
        input logic signed [W-1:0] e1x, input logic signed [W-1:0] e1y,
        input logic signed [W-1:0] px,  input logic signed [W-1:0] py
    );
        logic okx;
        logic oky;
        okx = ((e0x <= px) && (px <= e1x)) || ((e1x <= px) && (px <= e0x));
        oky = ((e0y <= py) && (py <= e1y)) || ((e1y <= py) && (py <= e0y));
        return okx && oky;
    endfunction

    // Difference of two coordinates, one bit wider
    function automatic logic signed [W:0] sub(
        input logic signed [W-1:0] p, input logic signed [W-1:0] q
    );
        logic signed [W:0] pe;
        logic signed [W:0] qe;
        pe = {p[W-1], p};
        qe = {q[W-1], q};
        return pe - qe;
    endfunction

    // Advance a stage when it is empty or the next one moves
    assign en4     = !vld4_reg || m_ready;
    assign en3     = !vld3_reg || en4;
    assign en2     = !vld2_reg || en3;
    assign en1     = !vld1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end else begin
            if (en1) vld1_reg <= s_valid;
            if (en2) vld2_reg <= vld1_reg;
            if (en3) vld3_reg <= vld2_reg;
            if (en4) vld4_reg <= vld3_reg;
        end
    end

    // Stage 1: box checks
    always_comb begin
        box1_next[O_ABC] = in_box(s_ax, s_ay, s_bx, s_by, s_cx, s_cy);
        box1_next[O_ABD] = in_box(s_ax, s_ay, s_bx, s_by, s_dx, s_dy);
        box1_next[O_CDA] = in_box(s_cx, s_cy, s_dx, s_dy, s_ax, s_ay);
        box1_next[O_CDB] = in_box(s_cx, s_cy, s_dx, s_dy, s_bx, s_by);
    end

    // Stage 1: edge and offset vectors
    always_ff @(posedge aclk) begin
        if (en1) begin
            ux_reg[O_ABC] <= sub(s_bx, s_ax);
            uy_reg[O_ABC] <= sub(s_by, s_ay);
            vx_reg[O_ABC] <= sub(s_cx, s_ax);
            vy_reg[O_ABC] <= sub(s_cy, s_ay);
            ux_reg[O_ABD] <= sub(s_bx, s_ax);
            uy_reg[O_ABD] <= sub(s_by, s_ay);
            vx_reg[O_ABD] <= sub(s_dx, s_ax);
            vy_reg[O_ABD] <= sub(s_dy, s_ay);
            ux_reg[O_CDA] <= sub(s_dx, s_cx);
            uy_reg[O_CDA] <= sub(s_dy, s_cy);
            vx_reg[O_CDA] <= sub(s_ax, s_cx);
            vy_reg[O_CDA] <= sub(s_ay, s_cy);
            ux_reg[O_CDB] <= sub(s_dx, s_cx);
            uy_reg[O_CDB] <= sub(s_dy, s_cy);
            vx_reg[O_CDB] <= sub(s_bx, s_cx);
            vy_reg[O_CDB] <= sub(s_by, s_cy);
            box1_reg      <= box1_next;
        end
    end

    // Stages 2 and 3: cross products and their compare
    assign oen.mul = en2;
    assign oen.cmp = en3;

    for (genvar k = 0; k < NOR; k++) begin : g_orient
        sit_orient #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_orient (
            .aclk   (aclk),
            .en     (oen),
            .ux     (ux_reg[k]),
            .uy     (uy_reg[k]),
            .vx     (vx_reg[k]),
            .vy     (vy_reg[k]),
            .orient (orient[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (en2) box2_reg <= box1_reg;
        if (en3) box3_reg <= box2_reg;
    end

    // Stage 4: a collinear endpoint in its box wins; any other collinear
    // endpoint drops the general case
    always_comb begin
        logic [NOR-1:0] coll;
        logic           general;
        for (int k = 0; k < NOR; k++) begin
            coll[k] = (orient[k] == ORIENT_COLLINEAR);
        end
        general  = (coll == '0)
                   && (orient[O_ABC] != orient[O_ABD])
                   && (orient[O_CDA] != orient[O_CDB]);
        hit_next = (|(coll & box3_reg)) || general;
    end

    always_ff @(posedge aclk) begin
        if (en4) hit_reg <= hit_next;
    end

    assign m_valid      = vld4_reg;
    assign m_intersects = hit_reg;

    // An accepted word lands in the first stage
    `SIT_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_valid && s_ready, vld1_reg,
        "accepted word missing from first stage")
    // A full stage that cannot move keeps its word
    `SIT_ASSERT_NEXT(a_hold_mid, aclk, aresetn, vld2_reg && !en3, vld2_reg,
        "stalled word dropped from multiply stage")
    // Input backpressure only when every stage is full
    `SIT_ASSERT_NOW(a_ready_full, aclk, aresetn, !s_ready,
        vld1_reg && vld2_reg && vld3_reg && vld4_reg && !m_ready,
        "input stalled with room in the pipeline")

endmodule

[rtl/sit_orient.sv]
// Orientation unit: two cross-product multiplies, registered, then a compare.
// Depends on sit_pkg.
module sit_orient
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                        aclk,
    input  sit_stage_en_t               en,
    input  logic signed [COORD_WIDTH:0] ux,
    input  logic signed [COORD_WIDTH:0] uy,
    input  logic signed [COORD_WIDTH:0] vx,
    input  logic signed [COORD_WIDTH:0] vy,
    output orient_t                     orient
);

    localparam int PW = 2 * COORD_WIDTH + 2;

    logic signed [PW-1:0] m1_reg;
    logic signed [PW-1:0] m2_reg;
    orient_t              orient_reg;
    orient_t              orient_next;

    // Multiply stage: form both halves of the cross product
    always_ff @(posedge aclk) begin
        if (en.mul) begin
            m1_reg <= ux * vy;
            m2_reg <= uy * vx;
        end
    end

    // Classify the turn
    always_comb begin
        if (m1_reg == m2_reg) begin
            orient_next = ORIENT_COLLINEAR;
        end else if (m1_reg > m2_reg) begin
            orient_next = ORIENT_POS;
        end else begin
            orient_next = ORIENT_NEG;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.cmp) begin
            orient_reg <= orient_next;
        end
    end

    assign orient = orient_reg;

endmodule
